>>> hdl/ase_pkg.sv
// Package for the arctan series evaluator: widths, limits and sequencer states.
// No dependencies.
package ase_pkg;
   localparam int DataWidth = 64;
   localparam int FracBits = 62;
   localparam int TolWidth = 63;
   localparam int CountWidth = 11;
   localparam int MaxTerms = 1024;
   localparam int TermWidth = 17;
   localparam logic [DataWidth-1:0] MagCap = {1'b0, {(DataWidth-1){1'b1}}};

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ_MUL, ST_SQ_WAIT, ST_DIV, ST_ACC, ST_PW_MUL, ST_PW_WAIT, ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic start;
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic start;
      logic [DataWidth-1:0] dividend;
      logic [TermWidth-1:0] divisor;
   } div_req_type;
endpackage

>>> hdl/arctan_series_evaluator.sv
// Top level of the arctan series evaluator: sequencer, accumulator, tolerance register.
// Depends on ase_pkg, ase_mul and ase_div.
//
// One argument at a time. busy is high from the start transfer until the result strobe;
// the result is on the rsp_ ports for one cycle and cannot be held off. The sequence: square
// x, then per term issue the divide, wait on the bit-serial divider, accumulate, and
// multiply for the next power. busy drops in the cycle after the result strobe; the
// number of terms N is at most 1024.
module arctan_series_evaluator (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [63:0] req_x_value,
   input  logic csr_write_enable,
   input  logic [62:0] csr_write_data,
   output logic rsp_valid,
   output logic signed [63:0] rsp_arctan_sum,
   output logic [10:0] rsp_term_count,
   output logic rsp_converged
);
   ase_pkg::seq_state_type state_ff, state_in;
   logic [62:0] tol_ff;
   logic [63:0] x2_ff, x2_in, pw_ff, pw_in, tmag_ff, tmag_in;
   logic signed [63:0] sum_ff, sum_in;
   logic neg_ff, neg_in, conv_ff, conv_in;
   logic [ase_pkg::TermWidth-1:0] n_ff, n_in;
   ase_pkg::mul_req_type mreq;
   ase_pkg::div_req_type dreq;
   logic mdone, ddone;
   logic [63:0] mres, dres, mag;
   logic signed [64:0] wide;

   ase_mul u_mul (.clock, .reset, .req(mreq), .done(mdone), .result(mres));
   ase_div u_div (.clock, .reset, .req(dreq), .done(ddone), .quotient(dres));

   always_comb begin
      mag = req_x_value[63] ? (~req_x_value + 64'd1) : req_x_value;
      if (mag > ase_pkg::MagCap) mag = ase_pkg::MagCap;
   end

   assign wide = neg_ff ? ({sum_ff[63], sum_ff} - {1'b0, tmag_ff})
                        : ({sum_ff[63], sum_ff} + {1'b0, tmag_ff});

   always_comb begin
      state_in = state_ff;
      x2_in = x2_ff;
      pw_in = pw_ff;
      tmag_in = tmag_ff;
      sum_in = sum_ff;
      neg_in = neg_ff;
      conv_in = conv_ff;
      n_in = n_ff;
      mreq = '0;
      dreq = '0;
      case (state_ff)
         ase_pkg::ST_IDLE: begin
            if (start) begin
               pw_in = mag;
               neg_in = req_x_value[63];
               sum_in = '0;
               n_in = ase_pkg::TermWidth'(1);
               conv_in = 1'b0;
               mreq.start = 1'b1;
               mreq.a = mag;
               mreq.b = mag;
               state_in = ase_pkg::ST_SQ_WAIT;
            end
         end
         ase_pkg::ST_SQ_WAIT: begin
            if (mdone) begin
               x2_in = mres;
               state_in = ase_pkg::ST_DIV;
            end
         end
         ase_pkg::ST_DIV: begin
            dreq.start = 1'b1;
            dreq.dividend = pw_ff;
            dreq.divisor = {n_ff[ase_pkg::TermWidth-2:0], 1'b0} - ase_pkg::TermWidth'(1);
            state_in = ase_pkg::ST_ACC;
         end
         ase_pkg::ST_ACC: begin
            if (ddone) begin
               tmag_in = dres;
               state_in = ase_pkg::ST_PW_MUL;
            end
         end
         ase_pkg::ST_PW_MUL: begin
            if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) sum_in = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (wide < -65'sh0_8000_0000_0000_0000) sum_in = {1'b1, 63'd0};
            else sum_in = wide[63:0];
            if (tmag_ff < {1'b0, tol_ff}) begin
               conv_in = 1'b1;
               state_in = ase_pkg::ST_DONE;
            end else if (n_ff == ase_pkg::TermWidth'(ase_pkg::MaxTerms)) begin
               state_in = ase_pkg::ST_DONE;
            end else begin
               mreq.start = 1'b1;
               mreq.a = pw_ff;
               mreq.b = x2_ff;
               state_in = ase_pkg::ST_PW_WAIT;
            end
         end
         ase_pkg::ST_PW_WAIT: begin
            if (mdone) begin
               pw_in = mres;
               neg_in = ~neg_ff;
               n_in = n_ff + ase_pkg::TermWidth'(1);
               state_in = ase_pkg::ST_DIV;
            end
         end
         ase_pkg::ST_DONE: state_in = ase_pkg::ST_IDLE;
         default: state_in = ase_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ase_pkg::ST_IDLE;
         tol_ff <= 63'd1;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) tol_ff <= csr_write_data;
      end
      x2_ff <= x2_in;
      pw_ff <= pw_in;
      tmag_ff <= tmag_in;
      sum_ff <= sum_in;
      neg_ff <= neg_in;
      conv_ff <= conv_in;
      n_ff <= n_in;
   end

   assign busy = (state_ff != ase_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == ase_pkg::ST_DONE);
   assign rsp_arctan_sum = sum_ff;
   assign rsp_converged = conv_ff;
   assign rsp_term_count = conv_ff ? n_ff[ase_pkg::CountWidth-1:0] : '0;

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start transfer not taken");
   a_n_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (n_ff <= ase_pkg::TermWidth'(ase_pkg::MaxTerms))) else $error("term count overrun");
endmodule

>>> hdl/ase_mul.sv
// Multi-cycle fixed-point multiplier: (a*b)>>FracBits saturated, one 32x32 product a cycle.
// Depends on ase_pkg.
module ase_mul (
   input  logic clock,
   input  logic reset,
   input  ase_pkg::mul_req_type req,
   output logic done,
   output logic [ase_pkg::DataWidth-1:0] result
);
   logic [1:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0] opa, opb;
   logic [63:0] prod;
   logic [127:0] shifted;
   logic done_ff, done_in;

   always_comb begin
      case (step_ff)
         2'd0: begin opa = a_ff[31:0];  opb = b_ff[31:0];  end
         2'd1: begin opa = a_ff[31:0];  opb = b_ff[63:32]; end
         2'd2: begin opa = a_ff[63:32]; opb = b_ff[31:0];  end
         default: begin opa = a_ff[63:32]; opb = b_ff[63:32]; end
      endcase
   end

   assign prod = opa * opb;

   always_comb begin
      case (step_ff)
         2'd0: shifted = {64'd0, prod};
         2'd3: shifted = {prod, 64'd0};
         default: shifted = {32'd0, prod, 32'd0};
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         a_in = req.a;
         b_in = req.b;
         acc_in = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + shifted;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

   // hi bits at and above FracBits+63 force saturation
   assign result = (acc_ff[127:ase_pkg::FracBits+ase_pkg::DataWidth] != '0 ||
                    acc_ff[ase_pkg::FracBits+ase_pkg::DataWidth-1])
                   ? ase_pkg::MagCap
                   : acc_ff[ase_pkg::FracBits +: ase_pkg::DataWidth];
   assign done = done_ff;
endmodule

>>> hdl/ase_div.sv
// Restoring divider, one quotient bit a cycle: 64-bit magnitude by a 17-bit odd number.
// Depends on ase_pkg.
module ase_div (
   input  logic clock,
   input  logic reset,
   input  ase_pkg::div_req_type req,
   output logic done,
   output logic [ase_pkg::DataWidth-1:0] quotient
);
   logic busy_ff, busy_in, done_ff, done_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [63:0] q_ff, q_in;
   logic [ase_pkg::TermWidth-1:0] d_ff, d_in;
   logic [ase_pkg::TermWidth:0] r_ff, r_in, trial;

   assign trial = {r_ff[ase_pkg::TermWidth-1:0], q_ff[63]};

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      q_in = q_ff;
      d_in = d_ff;
      r_in = r_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         q_in = req.dividend;
         d_in = req.divisor;
         r_in = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      d_ff <= d_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;
endmodule

>>> sim/tb_arctan_series_evaluator.sv
// Self-checking testbench for arctan_series_evaluator: a scoreboard class that sums the
// series itself, with plain tasks that drive arguments and tolerance writes.
// Depends on ase_pkg and the arctan_series_evaluator RTL.
`timescale 1ns / 1ps

module tb_arctan_series_evaluator;

   typedef struct {
      logic signed [ase_pkg::DataWidth-1:0] sum;
      logic [ase_pkg::CountWidth-1:0] count;
      logic conv;
   } arctan_result_type;

   class arctan_scoreboard;
      logic [ase_pkg::TolWidth-1:0] tolerance;
      arctan_result_type expected_q[$];
      int errors;
      int checked;

      function logic [ase_pkg::DataWidth-1:0] mul_frac(logic [ase_pkg::DataWidth-1:0] a,
                                                       logic [ase_pkg::DataWidth-1:0] b);
         logic [2*ase_pkg::DataWidth-1:0] p;
         p = (a * b) >> ase_pkg::FracBits;
         return (p > ase_pkg::MagCap) ? ase_pkg::MagCap : p[ase_pkg::DataWidth-1:0];
      endfunction

      function void note_argument(logic signed [ase_pkg::DataWidth-1:0] x);
         logic [ase_pkg::DataWidth-1:0] mag, x2, power, tmag;
         logic signed [ase_pkg::DataWidth:0] acc;
         logic signed [ase_pkg::DataWidth-1:0] sum;
         logic neg, done;
         arctan_result_type r;
         neg = x[ase_pkg::DataWidth-1];
         mag = neg ? -x : x;
         if (mag > ase_pkg::MagCap) mag = ase_pkg::MagCap;
         x2 = mul_frac(mag, mag);
         power = mag;
         sum = 0;
         done = 0;
         r.count = 0;
         for (int n = 1; n <= ase_pkg::MaxTerms; n++) begin
            tmag = power / (2 * n - 1);
            acc = neg ? $signed({sum[ase_pkg::DataWidth-1], sum}) - $signed({1'b0, tmag})
                      : $signed({sum[ase_pkg::DataWidth-1], sum}) + $signed({1'b0, tmag});
            if (acc > $signed({2'b00, ase_pkg::MagCap})) sum = ase_pkg::MagCap;
            else if (acc < -$signed({2'b00, ase_pkg::MagCap}) - 1)
               sum = {1'b1, {(ase_pkg::DataWidth-1){1'b0}}};
            else sum = acc[ase_pkg::DataWidth-1:0];
            if (tmag < {1'b0, tolerance}) begin
               r.count = n[ase_pkg::CountWidth-1:0];
               done = 1;
               break;
            end
            power = mul_frac(power, x2);
            neg = !neg;
         end
         r.sum = sum;
         r.conv = done;
         expected_q.push_back(r);
      endfunction

      function void check_result(logic signed [ase_pkg::DataWidth-1:0] sum,
                                 logic [ase_pkg::CountWidth-1:0] count, logic conv);
         arctan_result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result sum %h", $time, sum);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (sum !== e.sum) begin
            $display("%0t: arctan_sum expected %h actual %h", $time, e.sum, sum);
            errors++;
         end
         if (count !== e.count) begin
            $display("%0t: term_count expected %0d actual %0d", $time, e.count, count);
            errors++;
         end
         if (conv !== e.conv) begin
            $display("%0t: converged expected %b actual %b", $time, e.conv, conv);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset, start, busy;
   logic signed [63:0] req_x_value;
   logic csr_write_enable;
   logic [62:0] csr_write_data;
   logic rsp_valid;
   logic signed [63:0] rsp_arctan_sum;
   logic [10:0] rsp_term_count;
   logic rsp_converged;

   arctan_scoreboard sb;
   int sent;
   bit quiet;

   arctan_series_evaluator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x_value(req_x_value),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_arctan_sum(rsp_arctan_sum),
      .rsp_term_count(rsp_term_count), .rsp_converged(rsp_converged)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(64'd12 * 64'd60_000_000);
      $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_arctan_sum, rsp_term_count, rsp_converged);
   end

   task automatic send_argument(logic signed [63:0] x);
      if (!quiet && $urandom_range(2) == 0) repeat ($urandom_range(6, 1)) @(negedge clock);
      while (busy) @(negedge clock);
      start = 1;
      req_x_value = x;
      sb.note_argument(x);
      sent++;
      @(negedge clock);
      start = 0;
      req_x_value = {$urandom, $urandom};
   endtask

   task automatic write_tolerance(logic [62:0] v);
      while (sb.expected_q.size() != 0 || busy) @(negedge clock);
      csr_write_enable = 1;
      csr_write_data = v;
      sb.tolerance = v;
      @(negedge clock);
      csr_write_enable = 0;
   endtask

   function automatic logic signed [63:0] rand_arg(int lo, int hi);
      logic signed [63:0] v;
      v = {$urandom, $urandom};
      return v >>> $urandom_range(hi, lo);
   endfunction

   initial begin
      logic [62:0] tols[5];
      sb = new();
      sb.tolerance = 1;
      sent = 0;
      quiet = 0;
      reset = 1;
      start = 0;
      req_x_value = 0;
      csr_write_enable = 0;
      csr_write_data = 0;
      repeat (8) @(negedge clock);
      reset = 0;

      // reset tolerance: zero, tiny, extremes of the argument (limit hit)
      send_argument(0);
      send_argument(1);
      send_argument(-1);
      send_argument(64'sh7FFF_FFFF_FFFF_FFFF);
      send_argument(64'sh8000_0000_0000_0000);
      // zero tolerance never converges
      write_tolerance(0);
      send_argument(0);
      // tolerance extremes, then one; arguments near, at and beyond one, and a tiny argument
      write_tolerance(63'h7FFF_FFFF_FFFF_FFFF);
      send_argument(64'sh4000_0000_0000_0000);
      send_argument(-64'sh4000_0000_0000_0000);
      send_argument(64'sh7FFF_FFFF_FFFF_FFFF);
      send_argument(64'sh8000_0000_0000_0000);
      write_tolerance(63'h4000_0000_0000_0000);
      send_argument(64'sh3FFF_FFFF_FFFF_FFFF);
      send_argument(64'shC000_0000_0000_0001);
      send_argument(64'sh0000_0000_0000_0001);

      tols = '{63'h1000_0000_0000_0000, 63'h0000_0100_0000_0000,
               63'h0000_0000_0010_0000, 63'h4000_0000_0000_0000, 63'h0000_0400_0000_0000};
      for (int p = 0; p < 5; p++) begin
         write_tolerance(tols[p]);
         for (int i = 0; i < 120; i++) begin
            if (p == 4 && i >= 60) quiet = 1;
            if ($urandom_range(9) == 0) send_argument({$urandom, $urandom});
            else if (tols[p] < 63'h0000_0100_0000_0000) send_argument(rand_arg(5, 40));
            else send_argument(rand_arg(2, 40));
         end
      end

      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("%0d arguments sent over several tolerance settings, %0d results compared",
               sent, sb.checked);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

>>> files.f
hdl/ase_pkg.sv
hdl/ase_mul.sv
hdl/ase_div.sv
hdl/arctan_series_evaluator.sv
sim/tb_arctan_series_evaluator.sv
